// ----- rtl/skt_pkg.sv -----
// Shared types, widths and codes for the sorted key table.
// No dependencies; used by skt_cell and sorted_key_table.
`default_nettype none

package skt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int PRICE_W      = 32;
  localparam int ID_W         = 16;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 5;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [ID_W-1:0]    id;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic               en;
    logic               op;
    logic [PRICE_W-1:0] price;
    logic [ID_W-1:0]    id;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/skt_cell.sv -----
// One slot of the sorted table: holds an entry, compares it against the
// broadcast key and shifts with its neighbors. Depends on skt_pkg.
`default_nettype none

module skt_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire skt_pkg::ctrl_t ctrl_i,
  input  wire logic           prev_cond_i,  // insert point lies left of this cell
  input  wire logic           take_i,       // remove: pull from right neighbor
  input  wire skt_pkg::entry_t left_i,
  input  wire skt_pkg::entry_t right_i,
  output skt_pkg::entry_t      cur_o,
  output skt_pkg::entry_t      nxt_o,
  output logic                 cond_o,
  output logic                 match_o
);

  logic                        valid_r;
  logic [skt_pkg::PRICE_W-1:0] price_r;
  logic [skt_pkg::ID_W-1:0]    id_r;
  skt_pkg::entry_t             new_entry;

  assign cur_o   = '{valid: valid_r, price: price_r, id: id_r};
  // empty slot or price not below new key: insert point is here or earlier
  assign cond_o  = !valid_r || (price_r >= ctrl_i.price);
  assign match_o = valid_r && (id_r == ctrl_i.id);

  assign new_entry = '{valid: 1'b1, price: ctrl_i.price, id: ctrl_i.id};

  always_comb begin
    nxt_o = cur_o;
    if (ctrl_i.en) begin
      unique case (ctrl_i.op)
        skt_pkg::OP_INSERT: begin
          if (cond_o) begin
            nxt_o = prev_cond_i ? left_i : new_entry;
          end
        end
        skt_pkg::OP_REMOVE: begin
          if (take_i) begin
            nxt_o = right_i;
          end
        end
        default: nxt_o = cur_o;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= nxt_o.valid;
    end
  end

  always_ff @(posedge clk) begin
    price_r <= nxt_o.price;
    id_r    <= nxt_o.id;
  end

endmodule

`default_nettype wire

// ----- rtl/sorted_key_table.sv -----
// Sorted key table: up to CAPACITY (price, id) entries kept in ascending
// price order in a row of shift cells. Depends on skt_pkg and skt_cell.
`default_nettype none

// Each input beat is an insert or a remove-by-id. Insert places the entry
// ahead of the first stored entry whose price is not below its own (so it
// lands in front of equal prices); a full table drops it with status FULL.
// Remove deletes the first entry from the head whose id matches; a miss (or
// an empty table) leaves the table as is with status MISS. Every beat yields
// one result beat carrying status, entry count after the operation and the
// head entry (zeros when empty). Throughput is one item per clock: all cells
// compare against the broadcast key in parallel and shift by one slot in the
// same cycle, and the result is registered, so the result beat appears in the
// cycle after acceptance and the next item is taken while it waits, as long
// as the output register is free or being drained. The longest path is the
// first-match search over the cell match bits on remove (a CAPACITY-bit
// subtract). Entry payloads are not reset; only valid bits, the count and out_valid are.
module sorted_key_table #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_operation,
  input  wire logic [skt_pkg::PRICE_W-1:0]    in_price,
  input  wire logic [skt_pkg::ID_W-1:0]       in_item_id,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [skt_pkg::STATUS_W-1:0]        out_status,
  output logic [skt_pkg::COUNT_OUT_W-1:0]     out_entry_count,
  output logic [skt_pkg::PRICE_W-1:0]         out_head_price,
  output logic [skt_pkg::ID_W-1:0]            out_head_id
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic                  accept;
  logic                  full;
  logic                  hit;
  logic                  is_remove;
  logic [CW-1:0]         count_r, count_nxt;
  logic [skt_pkg::STATUS_W-1:0] status;
  skt_pkg::ctrl_t        ctrl;

  skt_pkg::entry_t       cur   [CAPACITY];
  skt_pkg::entry_t       nxt   [CAPACITY];
  logic [CAPACITY-1:0]   cond;
  logic [CAPACITY-1:0]   match;
  logic [CAPACITY-1:0]   match_m1;
  logic [CAPACITY-1:0]   first_oh;
  logic [CAPACITY-1:0]   take;
  logic [CAPACITY-1:0]   valid_vec;

  logic                          out_valid_r;
  logic [skt_pkg::STATUS_W-1:0]  status_r;
  logic [CW-1:0]                 ocount_r;
  logic [skt_pkg::PRICE_W-1:0]   head_price_r;
  logic [skt_pkg::ID_W-1:0]      head_id_r;
  logic [CW+skt_pkg::COUNT_OUT_W-1:0] count_ext;

  // ---- handshake: output register frees up when drained ----
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_remove = (in_operation == skt_pkg::OP_REMOVE);

  assign full = (count_r == CW'(CAPACITY));
  assign hit  = |match;

  // ---- first matching id from the head, and every cell at or after it ----
  // match ^ (match-1) marks all bits up to the lowest set bit; the lowest set
  // bit itself is kept, the bits above it are the cells that shift left.
  assign match_m1 = match - CAPACITY'(1);
  assign first_oh = match & ~match_m1;
  assign take     = ~(match ^ match_m1) | first_oh;

  always_comb begin
    status = skt_pkg::ST_DONE;
    if (is_remove) begin
      if (!hit) status = skt_pkg::ST_MISS;
    end else begin
      if (full) status = skt_pkg::ST_FULL;
    end
  end

  // dropped insert must not touch the cells
  assign ctrl = '{en:    accept && !(!is_remove && full),
                  op:    in_operation,
                  price: in_price,
                  id:    in_item_id};

  always_comb begin
    count_nxt = count_r;
    if (accept && (status == skt_pkg::ST_DONE)) begin
      count_nxt = is_remove ? (count_r - CW'(1)) : (count_r + CW'(1));
    end
  end

  // ---- row of cells ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skt_pkg::entry_t left_e, right_e;
    logic            prev_c;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign prev_c = 1'b0;
    end else begin : g_mid
      assign left_e = cur[i-1];
      assign prev_c = cond[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cur[i+1];
    end

    skt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl_i      (ctrl),
      .prev_cond_i (prev_c),
      .take_i      (take[i]),
      .left_i      (left_e),
      .right_i     (right_e),
      .cur_o       (cur[i]),
      .nxt_o       (nxt[i]),
      .cond_o      (cond[i]),
      .match_o     (match[i])
    );

    assign valid_vec[i] = cur[i].valid;
  end

  // ---- count and result registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // head comes from cell 0's next value: the table as it stands after the op
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status;
      ocount_r     <= count_nxt;
      head_price_r <= nxt[0].valid ? nxt[0].price : '0;
      head_id_r    <= nxt[0].valid ? nxt[0].id    : '0;
    end
  end

  assign count_ext = {{skt_pkg::COUNT_OUT_W{1'b0}}, ocount_r};

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_count = count_ext[skt_pkg::COUNT_OUT_W-1:0];
  assign out_head_price  = head_price_r;
  assign out_head_id     = head_id_r;

`ifndef SYNTH
  // count never exceeds the table size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // occupied cells track the count
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("valid cells disagree with entry count");

  // dropped insert leaves every cell's occupancy untouched
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_remove && full |=> $stable(valid_vec))
    else $error("insert into full table changed the cells");

  // reported head agrees with cell 0 after the operation
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_head_price == (cur[0].valid ? cur[0].price : '0)))
    else $error("head price does not match first cell");
`endif

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for sorted_key_table: directed table plus random
// insert/remove traffic, checked beat by beat against an in-bench price book.
// Depends on rtl/skt_pkg.sv and rtl/sorted_key_table.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;

  localparam int DEPTH        = CAPACITY_DEF;
  localparam int RAND_ITEMS   = 2000;
  localparam int PHASES       = 4;
  // Slowest legal run is roughly 2k beats with source idles and sink
  // stalls on each, so this leaves a wide margin.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int ID_POOL_MAX  = 48;

  // One result beat, field for field.
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count;
    logic [PRICE_W-1:0]     head_price;
    logic [ID_W-1:0]        head_id;
  } book_result_t;

  // One stimulus row; typed rows carry a hand-written expectation.
  typedef struct packed {
    logic               op;
    logic [PRICE_W-1:0] price;
    logic [ID_W-1:0]    id;
    logic               typed;
    book_result_t       exp;
  } stim_row_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_operation = OP_INSERT;
  logic [PRICE_W-1:0] in_price     = '0;
  logic [ID_W-1:0]    in_item_id   = '0;
  logic               out_ready    = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [COUNT_OUT_W-1:0] out_entry_count;
  logic [PRICE_W-1:0]     out_head_price;
  logic [ID_W-1:0]        out_head_id;

  // Side-band that travels with the payload, so the monitor knows
  // whether the accepted beat had a typed-in expectation.
  logic         row_typed = 1'b0;
  book_result_t row_exp   = '0;

  sorted_key_table #(
    .CAPACITY(DEPTH)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_price       (in_price),
    .in_item_id     (in_item_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_entry_count(out_entry_count),
    .out_head_price (out_head_price),
    .out_head_id    (out_head_id)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Price book: our own copy of the table, sorted ascending by price.
  // Only the first book_count slots are ever read.
  // ---------------------------------------------------------------------
  logic [PRICE_W-1:0] book_price [DEPTH];
  logic [ID_W-1:0]    book_id    [DEPTH];
  int unsigned        book_count = 0;

  book_result_t pending_results[$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  sink_stall_pct = 0;
  int unsigned  sent_ids[$];
  stim_row_t    directed_rows[$];
  book_result_t predicted;
  book_result_t want;
  book_result_t seen;

  // Apply one operation to the book and return the result beat it causes.
  function automatic book_result_t update_book(input logic op,
                                               input logic [PRICE_W-1:0] price,
                                               input logic [ID_W-1:0] id);
    book_result_t r;
    int unsigned  pos;
    r.status = ST_DONE;
    pos = 0;
    if (op == OP_INSERT) begin
      if (book_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // strict less-than: a new entry lands ahead of equal prices
        while (pos < book_count && book_price[pos] < price) pos++;
        for (int unsigned k = book_count; k > pos; k--) begin
          book_price[k] = book_price[k-1];
          book_id[k]    = book_id[k-1];
        end
        book_price[pos] = price;
        book_id[pos]    = id;
        book_count++;
      end
    end else begin
      // first match from the head wins on duplicate ids
      while (pos < book_count && book_id[pos] != id) pos++;
      if (pos >= book_count) begin
        r.status = ST_MISS;
      end else begin
        for (int unsigned k = pos; k + 1 < book_count; k++) begin
          book_price[k] = book_price[k+1];
          book_id[k]    = book_id[k+1];
        end
        book_count--;
      end
    end
    r.count      = book_count[COUNT_OUT_W-1:0];
    r.head_price = (book_count > 0) ? book_price[0] : '0;
    r.head_id    = (book_count > 0) ? book_id[0] : '0;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic op, input logic [PRICE_W-1:0] price,
                                       input logic [ID_W-1:0] id, input logic typed,
                                       input book_result_t exp);
    stim_row_t r;
    r.op    = op;
    r.price = price;
    r.id    = id;
    r.typed = typed;
    r.exp   = exp;
    return r;
  endfunction

  // Directed table. Typed expectations only where they are obvious.
  function automatic void build_directed();
    book_result_t none;
    none = '0;
    // remove on an empty table: miss, head reads as zero
    directed_rows.push_back(mk_row(OP_REMOVE, '0, '0, 1'b1, {ST_MISS, 5'd0, 32'd0, 16'd0}));
    // field extremes on the first insert
    directed_rows.push_back(mk_row(OP_INSERT, '1, '1, 1'b1,
                                   {ST_DONE, 5'd1, 32'hFFFF_FFFF, 16'hFFFF}));
    directed_rows.push_back(mk_row(OP_INSERT, '0, '0, 1'b1, {ST_DONE, 5'd2, 32'd0, 16'd0}));
    // equal price goes ahead of the one already stored
    directed_rows.push_back(mk_row(OP_INSERT, '0, 16'd5, 1'b1, {ST_DONE, 5'd3, 32'd0, 16'd5}));
    directed_rows.push_back(mk_row(OP_REMOVE, 32'h1234_5678, 16'd5, 1'b1,
                                   {ST_DONE, 5'd2, 32'd0, 16'd0}));
    // id not present
    directed_rows.push_back(mk_row(OP_REMOVE, '0, 16'h1234, 1'b1, {ST_MISS, 5'd2, 32'd0, 16'd0}));
    // duplicate ids: only the first one from the head goes
    directed_rows.push_back(mk_row(OP_INSERT, 32'd100, 16'd7, 1'b0, none));
    directed_rows.push_back(mk_row(OP_INSERT, 32'd100, 16'd7, 1'b0, none));
    directed_rows.push_back(mk_row(OP_REMOVE, '0, 16'd7, 1'b0, none));
    // fill up to capacity with nonzero prices so the head stays put
    for (int k = 0; k < DEPTH - 3; k++) begin
      directed_rows.push_back(mk_row(OP_INSERT, 32'd1 << k, ID_W'(16'h0100 + k), 1'b0, none));
    end
    // full table drops the insert
    directed_rows.push_back(mk_row(OP_INSERT, 32'd1, 16'hBEEF, 1'b1,
                                   {ST_FULL, 5'(DEPTH), 32'd0, 16'd0}));
    directed_rows.push_back(mk_row(OP_REMOVE, '1, '0, 1'b0, none));
    directed_rows.push_back(mk_row(OP_INSERT, '0, '1, 1'b0, none));
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return ID_W'($urandom_range(15));
    if (sel < 45) return '0;
    if (sel < 50) return '1;
    return ID_W'($urandom);
  endfunction

  // Random beat. Small id and price pools give hits and ties; the
  // insert share drifts so the table swings between empty and full.
  function automatic stim_row_t random_row(input int unsigned insert_pct);
    stim_row_t    r;
    int unsigned  sel;
    r = '0;
    sel = $urandom_range(99);
    if (sel < 25)      r.price = PRICE_W'($urandom_range(7));
    else if (sel < 30) r.price = '0;
    else if (sel < 35) r.price = '1;
    else               r.price = PRICE_W'($urandom);
    if ($urandom_range(99) < insert_pct) begin
      r.op = OP_INSERT;
      r.id = pick_id();
      sent_ids.push_back(r.id);
      if (sent_ids.size() > ID_POOL_MAX) void'(sent_ids.pop_front());
    end else begin
      r.op = OP_REMOVE;
      if (sent_ids.size() > 0 && $urandom_range(99) < 70)
        r.id = ID_W'(sent_ids[$urandom_range(sent_ids.size() - 1)]);
      else
        r.id = pick_id();
    end
    return r;
  endfunction

  // Present one beat; valid holds until in_ready is seen at an edge.
  task automatic send_beat(input stim_row_t row);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= row.op;
    in_price     <= row.price;
    in_item_id   <= row.id;
    row_typed    <= row.typed;
    row_exp      <= row.exp;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Monitor: accepted input beats feed the book; accepted result beats
  // are matched against the oldest expectation. Input side runs first so
  // a same-edge result would still find its expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = update_book(in_operation, in_price, in_item_id);
        pending_results.push_back(row_typed ? row_exp : predicted);
      end
      if (out_valid && out_ready) begin
        seen = {out_status, out_entry_count, out_head_price, out_head_id};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result beat: status %0d count %0d head %h/%h",
                     seen.status, seen.count, seen.head_price, seen.head_id);
        end else begin
          want = pending_results.pop_front();
          if (seen.status != want.status || seen.count != want.count ||
              seen.head_price != want.head_price || seen.head_id != want.head_id) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"result mismatch: exp status %0d count %0d head %h/%h,",
                        " got status %0d count %0d head %h/%h"},
                       want.status, want.count, want.head_price, want.head_id,
                       seen.status, seen.count, seen.head_price, seen.head_id);
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence: reset, directed rows, four idle/stall phases of random
  // traffic, then drain and report.
  // ---------------------------------------------------------------------
  initial begin : main_seq
    int unsigned phase_src  [PHASES];
    int unsigned phase_sink [PHASES];
    int unsigned insert_pct;
    phase_src  = '{0, 70, 0, 18};
    phase_sink = '{0, 0, 70, 18};
    insert_pct = 60;
    build_directed();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_beat(directed_rows[i]);

    for (int p = 0; p < PHASES; p++) begin
      src_idle_pct   = phase_src[p];
      sink_stall_pct = phase_sink[p];
      for (int i = 0; i < RAND_ITEMS / PHASES; i++) begin
        if (i % 50 == 0) insert_pct = $urandom_range(20, 85);
        send_beat(random_row(insert_pct));
      end
    end
    in_valid <= 1'b0;
    // the monitor queues the last accepted beat at that same edge
    @(posedge clk);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_table.sv
dv/testbench.sv
